// ----- hw/rtl/strk_pkg.sv -----
// ----------------------------------------------------------------------------
// strk_pkg: shared constants and types for the strike sequencer
// Field widths, command codes, wheel and level sizes, reset register values.
// ----------------------------------------------------------------------------
package strk_pkg;

  localparam int WHEEL_POSITIONS = 100;
  localparam int STRIKE_LEVELS   = 5;

  localparam int CMD_W      = 2;
  localparam int AXIS_W     = 2;
  localparam int CARRIAGE_W = 15;
  localparam int LINE_W     = 14;
  localparam int LETTER_W   = 7;
  localparam int LEVEL_W    = 4;
  localparam int WHEEL_W    = 7;
  localparam int TICK_W     = 16;
  localparam int RIBBON_W   = 14;
  localparam int STRENGTH_W = 8;
  localparam int HITS_W     = 2;
  localparam int ENTRY_W    = STRENGTH_W + HITS_W;
  localparam int TABLE_W    = 50;
  localparam int NUM_AXES   = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = TABLE_W;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  localparam logic [TICK_W-1:0]   ACTIVE_TICKS_RST   = 16'd15;
  localparam logic [TICK_W-1:0]   COOLDOWN_TICKS_RST = 16'd30;
  localparam logic [RIBBON_W-1:0] RIBBON_STEP_RST    = 14'd10;
  localparam logic [TABLE_W-1:0]  LEVEL_TABLE_RST    = 50'd1120121559423432;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_CHAR    = 2'd1,
    CMD_ARRIVED = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_TICKS   = 2'd0,
    REG_COOLDOWN_TICKS = 2'd1,
    REG_RIBBON_STEP    = 2'd2,
    REG_LEVEL_TABLE    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    AX_WAITING = 2'd0,
    AX_RUNNING = 2'd1,
    AX_AT_POS  = 2'd2
  } axis_state_t;

  typedef enum logic [1:0] {
    HM_WAITING = 2'd0,
    HM_ON      = 2'd1,
    HM_COOL    = 2'd2
  } hammer_phase_t;

  typedef struct packed {
    logic                  idle;
    logic [STRENGTH_W-1:0] hammer_drive;
    logic [RIBBON_W-1:0]   ribbon_advance;
    logic [WHEEL_W-1:0]    wheel_delta;
    logic [LINE_W-1:0]     line_target;
    logic [CARRIAGE_W-1:0] carriage_target;
    logic                  issue_moves;
    logic                  accepted;
  } result_t;

endpackage

// ----- hw/rtl/strike_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// strike_sequencer_core: character strike sequencer
// Issues axis targets for a new character and runs the hammer on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one transaction per event. in_tuser carries the
//   command (tick, new character, axis arrived); in_tdata carries axis id,
//   carriage, line and letter goals and the strike level.
//   Output stream (out_*): exactly one result transaction per input
//   transaction, in order: accepted/issue flags, targets, wheel delta,
//   ribbon advance, hammer drive and the idle flag after the event.
//   Config port (cfg_*): register writes, always ready; write only while idle.
// Timing:
//   The event is decoded and the state updated at the accepting edge; the
//   result sits in the output register from the next cycle. Throughput is
//   one transaction per cycle while the receiver does not stall, set by the
//   single result register.
// Reset and stall:
//   Reset returns all axes and the hammer to waiting, the wheel to the home
//   letter and the registers to their defaults. While the receiver stalls
//   the result holds and in_tready drops until the output register drains.
module strike_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fields from bit 0: axis_id, carriage_goal, line_goal, letter_goal,
  // strike_level, zero fill
  input  logic [strk_pkg::IN_TDATA_W-1:0]    in_tdata,
  // fields from bit 0: command
  input  logic [strk_pkg::CMD_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fields from bit 0: accepted, issue_moves, carriage_target, line_target,
  // wheel_delta, ribbon_advance, hammer_drive, idle, zero fill
  output logic [strk_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [strk_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [strk_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import strk_pkg::*;

  localparam int HALF_WHEEL = WHEEL_POSITIONS / 2;
  localparam int DIFF_W     = WHEEL_W + 2;
  localparam int LVL_IDX_W  = (STRIKE_LEVELS > 1) ? $clog2(STRIKE_LEVELS) : 1;
  localparam logic [LETTER_W-1:0] LETTER_MAX = LETTER_W'(WHEEL_POSITIONS - 1);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = LEVEL_W'(STRIKE_LEVELS - 1);

  // configuration registers
  logic [TICK_W-1:0]   active_ticks_r;
  logic [TICK_W-1:0]   cooldown_ticks_r;
  logic [RIBBON_W-1:0] ribbon_step_r;
  logic [TABLE_W-1:0]  level_table_r;

  // sequencer state
  axis_state_t           axis_r       [NUM_AXES];
  axis_state_t           axis_nxt     [NUM_AXES];
  hammer_phase_t         phase_r,     phase_nxt;
  logic [HITS_W-1:0]     hits_r,      hits_nxt;
  logic [STRENGTH_W-1:0] strength_r,  strength_nxt;
  logic [TICK_W-1:0]     timer_r,     timer_nxt;
  logic [WHEEL_W-1:0]    wheel_pos_r, wheel_pos_nxt;

  logic    out_valid_r;
  result_t result_r, result_nxt;

  cmd_t                  cmd_c;
  logic [AXIS_W-1:0]     axis_id_c;
  logic [CARRIAGE_W-1:0] carriage_c;
  logic [LINE_W-1:0]     line_c;
  logic [LETTER_W-1:0]   letter_c, letter_clamp_c;
  logic [LEVEL_W-1:0]    level_c,  level_clamp_c;
  logic [LVL_IDX_W-1:0]  level_idx_c;
  logic [ENTRY_W-1:0]    entry_c;
  logic signed [DIFF_W-1:0] diff_c, delta_c;
  logic                  all_waiting_c, all_at_pos_c, idle_nxt_c;
  logic [TICK_W-1:0]     timer_inc_c, limit_c;
  logic                  in_fire;

  assign cmd_c      = cmd_t'(in_tuser);
  assign axis_id_c  = in_tdata[1:0];
  assign carriage_c = in_tdata[16:2];
  assign line_c     = in_tdata[30:17];
  assign letter_c   = in_tdata[37:31];
  assign level_c    = in_tdata[41:38];

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_r};

  always_comb begin
    all_waiting_c = (phase_r == HM_WAITING);
    all_at_pos_c  = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (axis_r[i] != AX_WAITING) all_waiting_c = 1'b0;
      if (axis_r[i] != AX_AT_POS)  all_at_pos_c  = 1'b0;
    end
  end

  // clamp and look up the level entry, shortest-way wheel delta
  always_comb begin
    letter_clamp_c = (letter_c > LETTER_MAX) ? LETTER_MAX : letter_c;
    level_clamp_c  = (level_c > LEVEL_MAX) ? LEVEL_MAX : level_c;
    level_idx_c    = level_clamp_c[LVL_IDX_W-1:0];
    entry_c        = level_table_r[level_idx_c * ENTRY_W +: ENTRY_W];
    diff_c = $signed({2'b00, letter_clamp_c}) - $signed({2'b00, wheel_pos_r});
    if (diff_c > DIFF_W'(HALF_WHEEL)) begin
      delta_c = diff_c - DIFF_W'(WHEEL_POSITIONS);
    end else if (diff_c < -DIFF_W'(HALF_WHEEL)) begin
      delta_c = diff_c + DIFF_W'(WHEEL_POSITIONS);
    end else begin
      delta_c = diff_c;
    end
  end

  assign timer_inc_c = (timer_r != {TICK_W{1'b1}}) ? timer_r + 1'b1 : timer_r;
  assign limit_c     = (phase_r == HM_ON) ? active_ticks_r : cooldown_ticks_r;

  always_comb begin
    axis_nxt      = axis_r;
    phase_nxt     = phase_r;
    hits_nxt      = hits_r;
    strength_nxt  = strength_r;
    timer_nxt     = timer_r;
    wheel_pos_nxt = wheel_pos_r;
    result_nxt    = '0;

    case (cmd_c)
      CMD_CHAR: begin
        if (all_waiting_c) begin
          strength_nxt  = entry_c[STRENGTH_W-1:0];
          hits_nxt      = entry_c[ENTRY_W-1:STRENGTH_W];
          wheel_pos_nxt = letter_clamp_c;
          for (int i = 0; i < NUM_AXES; i++) axis_nxt[i] = AX_RUNNING;
          result_nxt.accepted        = 1'b1;
          result_nxt.issue_moves     = 1'b1;
          result_nxt.carriage_target = carriage_c;
          result_nxt.line_target     = line_c;
          result_nxt.wheel_delta     = delta_c[WHEEL_W-1:0];
          result_nxt.ribbon_advance  = ribbon_step_r;
        end
      end
      CMD_ARRIVED: begin
        if (axis_r[axis_id_c] == AX_RUNNING) axis_nxt[axis_id_c] = AX_AT_POS;
      end
      CMD_TICK: begin
        if (all_at_pos_c) begin
          if (phase_r == HM_WAITING) begin
            if (hits_r != '0) begin
              phase_nxt = HM_ON;
              timer_nxt = '0;
              hits_nxt  = hits_r - 1'b1;
            end else begin
              // last hit done: release all axes
              for (int i = 0; i < NUM_AXES; i++) axis_nxt[i] = AX_WAITING;
            end
          end else if (timer_inc_c >= limit_c) begin
            phase_nxt = (phase_r == HM_ON) ? HM_COOL : HM_WAITING;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_inc_c;
          end
        end
      end
      default: begin
      end
    endcase

    idle_nxt_c = (phase_nxt == HM_WAITING);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (axis_nxt[i] != AX_WAITING) idle_nxt_c = 1'b0;
    end
    result_nxt.hammer_drive = (phase_nxt == HM_ON) ? strength_nxt : '0;
    result_nxt.idle         = idle_nxt_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ticks_r   <= ACTIVE_TICKS_RST;
      cooldown_ticks_r <= COOLDOWN_TICKS_RST;
      ribbon_step_r    <= RIBBON_STEP_RST;
      level_table_r    <= LEVEL_TABLE_RST;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_ACTIVE_TICKS:   active_ticks_r   <= cfg_data[TICK_W-1:0];
        REG_COOLDOWN_TICKS: cooldown_ticks_r <= cfg_data[TICK_W-1:0];
        REG_RIBBON_STEP:    ribbon_step_r    <= cfg_data[RIBBON_W-1:0];
        REG_LEVEL_TABLE:    level_table_r    <= cfg_data[TABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) axis_r[i] <= AX_WAITING;
      phase_r     <= HM_WAITING;
      hits_r      <= '0;
      strength_r  <= '0;
      timer_r     <= '0;
      wheel_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        axis_r      <= axis_nxt;
        phase_r     <= phase_nxt;
        hits_r      <= hits_nxt;
        strength_r  <= strength_nxt;
        timer_r     <= timer_nxt;
        wheel_pos_r <= wheel_pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        // drain the result transaction
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) result_r <= result_nxt;
  end

endmodule
